// File: hw/rtl/lsf_pkg.sv
`timescale 1ns / 1ps
package lsf_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_point;
  } sample_t;

  typedef struct packed {
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic [8:0]         point_count;
    logic               degenerate;
    logic               overflowed;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               keep;
    logic               last;
  } item_t;

endpackage

// File: hw/rtl/lsf_front.sv
`timescale 1ns / 1ps
module lsf_front import lsf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sample_t sample,
  input  logic    full,
  output logic    busy,
  output logic    push,
  output item_t   item
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count;
  logic          keep;

  assign busy = full;
  assign push = start && !full;
  assign keep = count < CW'(MAX_POINTS);

  assign item.x    = sample.sample_x;
  assign item.y    = sample.sample_y;
  assign item.keep = keep;
  assign item.last = sample.last_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (sample.last_point) begin
        count <= '0;
      end else if (keep) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lsf_queue.sv
`timescale 1ns / 1ps
module lsf_queue import lsf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  full,
  output logic  valid
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t         slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;

  assign full    = fill == (AW+1)'(QUEUE_DEPTH);
  assign valid   = fill != '0;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (AW+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/lsf_back.sv
`timescale 1ns / 1ps
module lsf_back import lsf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    valid,
  output logic    pop,
  output logic    done,
  output result_t result
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SXW = 16 + CW;
  localparam int SQW = 32 + CW;
  localparam int NW  = 33 + 2 * CW;
  localparam int PW  = 48 + SXW;
  localparam int DW  = (NW + 16 > PW + 2) ? NW + 16 : PW + 2;
  localparam int CTW = $clog2(DW);

  typedef enum logic [7:0] {
    S_ACC  = 8'b00000001,
    S_MUL  = 8'b00000010,
    S_MULD = 8'b00000100,
    S_CHK  = 8'b00001000,
    S_DIVS = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_DIVD = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  typedef enum logic [2:0] {
    ST_NSXY,
    ST_SXSY,
    ST_NSXX,
    ST_SXSX,
    ST_SLSX,
    ST_SLOPE,
    ST_ICPT
  } step_t;

  state_t state;
  step_t  step;

  logic [CW-1:0]         n;
  logic signed [SXW-1:0] sx, sy;
  logic signed [SQW-1:0] sxx, sxy;
  logic                  dropped;

  logic signed [47:0]    ma;
  logic signed [SXW-1:0] mb;
  logic signed [PW-1:0]  acc;
  logic [CTW-1:0]        cnt;
  logic signed [NW-1:0]  num, den;
  logic signed [DW-1:0]  dvd;
  logic [DW-1:0]         mag;
  logic [NW-1:0]         rem, dvs;
  logic                  neg;
  logic signed [47:0]    slope_r, icpt_r;
  logic                  degen;

  logic signed [31:0]    pxx, pxy;
  logic signed [PW-1:0]  ax, addend, acc_n;
  logic [NW:0]           rem_sh, diff;
  logic                  ge;
  logic [DW-1:0]         limit, qs;
  logic signed [47:0]    quot;

  assign pop = (state == S_ACC) && valid;
  assign pxx = item.x * item.x;
  assign pxy = item.x * item.y;

  assign ax     = PW'(ma);
  assign addend = mb[SXW-1] ? ((cnt == CTW'(SXW - 1)) ? -ax : ax) : '0;
  assign acc_n  = (acc <<< 1) + addend;

  assign rem_sh = {rem, mag[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = !diff[NW];

  assign limit = neg ? (DW'(1) << 47) : ((DW'(1) << 47) - DW'(1));
  assign qs    = (mag > limit) ? limit : mag;
  assign quot  = neg ? -$signed(qs[47:0]) : $signed(qs[47:0]);

  assign done               = state == S_EMIT;
  assign result.slope       = slope_r;
  assign result.intercept   = icpt_r;
  assign result.point_count = 9'(n);
  assign result.degenerate  = degen;
  assign result.overflowed  = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_ACC;
      n       <= '0;
      sx      <= '0;
      sy      <= '0;
      sxx     <= '0;
      sxy     <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        S_ACC: begin
          if (valid) begin
            if (item.keep) begin
              n   <= n + CW'(1);
              sx  <= sx + SXW'(item.x);
              sy  <= sy + SXW'(item.y);
              sxx <= sxx + SQW'(pxx);
              sxy <= sxy + SQW'(pxy);
            end else begin
              dropped <= 1'b1;
            end
            if (item.last) begin
              ma    <= 48'(item.keep ? sxy + SQW'(pxy) : sxy);
              mb    <= SXW'({1'b0, item.keep ? n + CW'(1) : n});
              acc   <= '0;
              cnt   <= CTW'(SXW - 1);
              step  <= ST_NSXY;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          acc <= acc_n;
          mb  <= mb <<< 1;
          cnt <= cnt - CTW'(1);
          if (cnt == '0) begin
            state <= S_MULD;
          end
        end
        S_MULD: begin
          acc <= '0;
          cnt <= CTW'(SXW - 1);
          unique case (step)
            ST_NSXY: begin
              num   <= NW'(acc);
              ma    <= 48'(sx);
              mb    <= sy;
              step  <= ST_SXSY;
              state <= S_MUL;
            end
            ST_SXSY: begin
              num   <= num - NW'(acc);
              ma    <= 48'(sxx);
              mb    <= SXW'({1'b0, n});
              step  <= ST_NSXX;
              state <= S_MUL;
            end
            ST_NSXX: begin
              den   <= NW'(acc);
              ma    <= 48'(sx);
              mb    <= sx;
              step  <= ST_SXSX;
              state <= S_MUL;
            end
            ST_SXSX: begin
              den   <= den - NW'(acc);
              state <= S_CHK;
            end
            default: begin
              dvd   <= (DW'(sy) <<< 16) - DW'(acc);
              dvs   <= NW'({1'b0, n});
              step  <= ST_ICPT;
              state <= S_DIVS;
            end
          endcase
        end
        S_CHK: begin
          degen <= (n < CW'(2)) || den[NW-1] || (den == '0);
          if ((n < CW'(2)) || den[NW-1] || (den == '0)) begin
            slope_r <= '0;
            icpt_r  <= '0;
            state   <= S_EMIT;
          end else begin
            dvd   <= DW'(num) <<< 16;
            dvs   <= den;
            step  <= ST_SLOPE;
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          neg   <= dvd[DW-1];
          mag   <= dvd[DW-1] ? DW'(-dvd) : DW'(dvd);
          rem   <= '0;
          cnt   <= CTW'(DW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? diff[NW-1:0] : rem_sh[NW-1:0];
          mag <= {mag[DW-2:0], ge};
          cnt <= cnt - CTW'(1);
          if (cnt == '0) begin
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (step == ST_SLOPE) begin
            slope_r <= quot;
            ma      <= quot;
            mb      <= sx;
            acc     <= '0;
            cnt     <= CTW'(SXW - 1);
            step    <= ST_SLSX;
            state   <= S_MUL;
          end else begin
            icpt_r <= quot;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          n       <= '0;
          sx      <= '0;
          sy      <= '0;
          sxx     <= '0;
          sxy     <= '0;
          dropped <= 1'b0;
          state   <= S_ACC;
        end
        default: begin
          state <= S_ACC;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/least_squares_line_fit.sv
`timescale 1ns / 1ps
// Least-squares straight-line fit over a stream of signed 16-bit points.
// Input: a beat of sample (x, y, last_point) is taken on a rising edge with
// start high and busy low. Each beat enters a four-entry queue; the back end
// folds one point per cycle, while no fit is running, into the count and
// the sums of x, y, x*x, x*y. Points past MAX_POINTS are dropped and
// reported through overflowed. A beat with last_point starts the fit: five
// shift-add multiplies and two restoring divisions, one quotient bit per
// cycle; a degenerate fit ends after the fourth multiply. Points sent
// meanwhile wait in the queue, and busy rises only once the queue is full.
// Output: done is high for one cycle with result valid; the receiver takes it
// on that cycle and cannot hold it off. Slope and intercept are Q31.16,
// saturated to 48 bits; degenerate fits report zero.
// Reset (synchronous, active high) empties the queue and clears all sums.
module least_squares_line_fit import lsf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  sample_t sample,
  output logic    done,
  output result_t result
);

  item_t front_item, queue_item;
  logic  push, pop, full, valid;

  lsf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .full(full),
    .busy(busy), .push(push), .item(front_item)
  );

  lsf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_item(front_item), .pop(pop),
    .rd_item(queue_item), .full(full), .valid(valid)
  );

  lsf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst(rst), .item(queue_item), .valid(valid), .pop(pop),
    .done(done), .result(result)
  );

endmodule
